// ===== rtl/qsg_pkg.sv =====
// Package for the quadrature sine generator: sizes, types and the quarter-wave sine table.
`default_nettype none
package qsg_pkg;

  localparam int PHASE_BITS = 32;
  localparam int TABLE_BITS = 12;
  localparam int OFF_BITS   = TABLE_BITS - 2;
  localparam int QUARTER    = 1 << OFF_BITS;
  localparam int CFG_BITS   = 32;
  localparam int IDX_BITS   = 16;
  localparam int VAL_BITS   = 16;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [14:0] FULL_SCALE  = 15'd32767;

  typedef enum logic [1:0] {
    CFG_AMPLITUDE  = 2'd0,
    CFG_PHASE_STEP = 2'd1,
    CFG_POINT_CNT  = 2'd2
  } cfg_idx_e;

  // one tick as classified by the front end
  typedef struct packed {
    logic [IDX_BITS-1:0]   sample_index;
    logic [TABLE_BITS-1:0] addr;
    logic                  last;
  } tick_t;

  typedef logic [14:0] sine_rom_t [QUARTER];

  function automatic logic [63:0] taylor_step(input logic [63:0] t, input logic [63:0] x);
    logic [63:0] p;
    p = (t * x) >> 30;
    return (p * x) >> 30;
  endfunction

  // round(32767*sin(k*pi/2^(TABLE_BITS-1))), Q2.30 Taylor series to x^13
  function automatic logic [14:0] sine_entry(input int k);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x = (64'(k) * HALF_PI_Q30) >> OFF_BITS;
    t = x;
    s = x;
    t = taylor_step(t, x) / 64'd6;
    s = (s >= t) ? s - t : 64'd0;
    t = taylor_step(t, x) / 64'd20;
    s = s + t;
    t = taylor_step(t, x) / 64'd42;
    s = (s >= t) ? s - t : 64'd0;
    t = taylor_step(t, x) / 64'd72;
    s = s + t;
    t = taylor_step(t, x) / 64'd110;
    s = (s >= t) ? s - t : 64'd0;
    t = taylor_step(t, x) / 64'd156;
    s = s + t;
    r = (s * 64'd32767 + 64'd536870912) >> 30;
    return r[14:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < QUARTER; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // signed unit sine at a table address, quadrant folded onto the quarter table
  function automatic logic signed [16:0] unit_sine(input logic [TABLE_BITS-1:0] addr);
    logic [1:0]          quad;
    logic [OFF_BITS-1:0] off;
    logic [OFF_BITS:0]   pos;
    logic [14:0]         mag;
    quad = addr[TABLE_BITS-1 -: 2];
    off  = addr[OFF_BITS-1:0];
    pos  = quad[0] ? ((OFF_BITS+1)'(QUARTER) - {1'b0, off}) : {1'b0, off};
    mag  = pos[OFF_BITS] ? FULL_SCALE : SINE_ROM[pos[OFF_BITS-1:0]];
    return quad[1] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  endfunction

endpackage
`default_nettype wire

// ===== rtl/qsg_in_if.sv =====
// Tick input channel: valid/ready handshake carrying the restart flag.
`default_nettype none
interface qsg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface
`default_nettype wire

// ===== rtl/qsg_out_if.sv =====
// Sample output channel: valid/ready handshake carrying index, sine, cosine and last flag.
`default_nettype none
interface qsg_out_if;
  logic                valid;
  logic                ready;
  logic [15:0]         sample_index;
  logic signed [15:0]  sine_value;
  logic signed [15:0]  cosine_value;
  logic                last_sample;

  modport source (output valid, output sample_index, output sine_value,
                  output cosine_value, output last_sample, input ready);
  modport sink   (input valid, input sample_index, input sine_value,
                  input cosine_value, input last_sample, output ready);
endinterface
`default_nettype wire

// ===== rtl/qsg_front.sv =====
// Front end: phase accumulator and sample counter, one tick per transfer.
`default_nettype none
module qsg_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  qsg_in_if.sink                         in_ch,
  input  wire logic [qsg_pkg::CFG_BITS-1:0] phase_step_i,
  input  wire logic [qsg_pkg::IDX_BITS-1:0] point_count_i,
  input  wire logic                      full_i,
  output logic                           push_o,
  output qsg_pkg::tick_t                 tick_o
);
  import qsg_pkg::*;

  logic [PHASE_BITS-1:0] phase_q, phase_d, phase_cur;
  logic [IDX_BITS-1:0]   cnt_q, cnt_d, cnt_cur;
  logic [IDX_BITS:0]     count_eff;
  logic                  last;

  assign in_ch.ready = ~full_i;
  assign push_o      = in_ch.valid & ~full_i;

  assign phase_cur = in_ch.restart ? '0 : phase_q;
  assign cnt_cur   = in_ch.restart ? '0 : cnt_q;
  assign count_eff = (point_count_i == '0) ? (IDX_BITS+1)'(1) : {1'b0, point_count_i};
  assign last      = ({1'b0, cnt_cur} + (IDX_BITS+1)'(1)) >= count_eff;

  assign tick_o.sample_index = cnt_cur;
  assign tick_o.addr         = phase_cur[PHASE_BITS-1 -: TABLE_BITS];
  assign tick_o.last         = last;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (push_o) begin
      if (last) begin
        phase_d = '0;
        cnt_d   = '0;
      end else begin
        phase_d = phase_cur + PHASE_BITS'(phase_step_i);
        cnt_d   = cnt_cur + IDX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  a_wrap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && last) |=> (cnt_q == '0 && phase_q == '0))
    else $error("counter or phase not cleared after last sample");

endmodule
`default_nettype wire

// ===== rtl/qsg_fifo.sv =====
// Two-entry queue between front end and sample datapath.
`default_nettype none
module qsg_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire qsg_pkg::tick_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                avail_o,
  output qsg_pkg::tick_t      data_o
);
  import qsg_pkg::*;

  tick_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign avail_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_q ^ push_i;
      rd_q  <= rd_q ^ pop_i;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> avail_o) else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_q != rd_q)) else $error("pointers disagree with count");

endmodule
`default_nettype wire

// ===== rtl/qsg_back.sv =====
// Sample datapath: quadrant table lookup, amplitude multiply, rounding, output register.
`default_nettype none
module qsg_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        avail_i,
  input  wire qsg_pkg::tick_t              tick_i,
  output logic                             pop_o,
  input  wire logic signed [qsg_pkg::VAL_BITS-1:0] amplitude_i,
  qsg_out_if.source                        out_ch
);
  import qsg_pkg::*;

  logic en;

  logic                        v1_q, v2_q, vo_q;
  logic [IDX_BITS-1:0]         idx1_q, idx2_q, idxo_q;
  logic                        last1_q, last2_q, lasto_q;
  logic signed [16:0]          sin1_q, cos1_q;
  logic signed [32:0]          sinp_q, cosp_q;
  logic signed [32:0]          sin_r, cos_r;
  logic signed [VAL_BITS-1:0]  sino_q, coso_q;
  logic [TABLE_BITS-1:0]       cos_addr;

  assign en       = ~vo_q | out_ch.ready;
  assign pop_o    = en & avail_i;
  assign cos_addr = tick_i.addr + TABLE_BITS'(QUARTER);

  assign sin_r = (sinp_q + 33'sd16384) >>> 15;
  assign cos_r = (cosp_q + 33'sd16384) >>> 15;

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx1_q  <= tick_i.sample_index;
      last1_q <= tick_i.last;
      sin1_q  <= unit_sine(tick_i.addr);
      cos1_q  <= unit_sine(cos_addr);
      idx2_q  <= idx1_q;
      last2_q <= last1_q;
      sinp_q  <= amplitude_i * sin1_q;
      cosp_q  <= amplitude_i * cos1_q;
      idxo_q  <= idx2_q;
      lasto_q <= last2_q;
      sino_q  <= sin_r[VAL_BITS-1:0];
      coso_q  <= cos_r[VAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= avail_i;
      v2_q <= v1_q;
      vo_q <= v2_q;
    end
  end

  assign out_ch.valid        = vo_q;
  assign out_ch.sample_index = idxo_q;
  assign out_ch.sine_value   = sino_q;
  assign out_ch.cosine_value = coso_q;
  assign out_ch.last_sample  = lasto_q;

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v2_q) |=> vo_q) else $error("stage two result lost");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(v1_q) && $stable(v2_q))) else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

// ===== rtl/quadrature_sine_generator.sv =====
// Top level of the quadrature sine generator (numerically controlled oscillator).
//
// Each tick transfer yields one sample transfer carrying the index in the run,
// amplitude*sin and amplitude*cos of the current phase, and a last-sample flag.
// Throughput is one tick per clock while the queue is not full; a tick is written
// to the queue at its transfer, then passes the table lookup, multiply and rounded
// output registers before its sample is offered on the output. A two-entry queue
// between the phase front end and the datapath lets either side stall alone.
// The user must write configuration through cfg_we_i / cfg_idx_i / cfg_data_i
// only while no tick is in flight; the block itself does not enforce this.
// Index 0 amplitude, 1 phase step, 2 point count; other indexes are ignored.
`default_nettype none
module quadrature_sine_generator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [1:0]                      cfg_idx_i,
  input  wire logic [qsg_pkg::CFG_BITS-1:0]    cfg_data_i,
  qsg_in_if.sink                               in_ch,
  qsg_out_if.source                            out_ch
);
  import qsg_pkg::*;

  logic signed [VAL_BITS-1:0] amplitude_q;
  logic [CFG_BITS-1:0]        phase_step_q;
  logic [IDX_BITS-1:0]        point_count_q;

  logic  push, full, pop, avail;
  tick_t tick_in, tick_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amplitude_q   <= '0;
      phase_step_q  <= '0;
      point_count_q <= IDX_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_AMPLITUDE:  amplitude_q   <= cfg_data_i[VAL_BITS-1:0];
        CFG_PHASE_STEP: phase_step_q  <= cfg_data_i;
        CFG_POINT_CNT:  point_count_q <= cfg_data_i[IDX_BITS-1:0];
        default: ;
      endcase
    end
  end

  qsg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_ch),
    .phase_step_i  (phase_step_q),
    .point_count_i (point_count_q),
    .full_i        (full),
    .push_o        (push),
    .tick_o        (tick_in)
  );

  qsg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (tick_in),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .data_o  (tick_out)
  );

  qsg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .tick_i      (tick_out),
    .pop_o       (pop),
    .amplitude_i (amplitude_q),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire
